>>> src/mclc_pkg.sv
// ----------------------------------------------------------------------------
// mclc_pkg: shared types and constants of the mip chain layout checker
// Format codes, status codes, register indexes, block geometry per format
// and the reciprocal constants used by the shared multiplier.
// ----------------------------------------------------------------------------
`default_nettype none

package mclc_pkg;

    // Status codes of the verdict
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_HEADER   = 3'd1;
    localparam logic [2:0] ST_GENERATE = 3'd2;
    localparam logic [2:0] ST_LIMIT    = 3'd3;
    localparam logic [2:0] ST_LEVEL    = 3'd4;
    localparam logic [2:0] ST_TOTAL    = 3'd5;

    // Configuration register indexes
    localparam logic [2:0] CFG_FORMAT   = 3'd0;
    localparam logic [2:0] CFG_BASE_W   = 3'd1;
    localparam logic [2:0] CFG_BASE_H   = 3'd2;
    localparam logic [2:0] CFG_GENERATE = 3'd3;
    localparam logic [2:0] CFG_TOTAL    = 3'd4;

    // Format codes
    localparam logic [4:0] FMT_RGBA8       = 5'd0;
    localparam logic [4:0] FMT_BC7         = 5'd1;
    localparam logic [4:0] FMT_BC7_SRGB    = 5'd2;
    localparam logic [4:0] FMT_BC3         = 5'd3;
    localparam logic [4:0] FMT_ETC2        = 5'd4;
    localparam logic [4:0] FMT_ASTC_4X4    = 5'd5;
    localparam logic [4:0] FMT_ASTC_5X4    = 5'd6;
    localparam logic [4:0] FMT_ASTC_5X5    = 5'd7;
    localparam logic [4:0] FMT_ASTC_6X5    = 5'd8;
    localparam logic [4:0] FMT_ASTC_6X6    = 5'd9;
    localparam logic [4:0] FMT_ASTC_8X5    = 5'd10;
    localparam logic [4:0] FMT_ASTC_8X6    = 5'd11;
    localparam logic [4:0] FMT_ASTC_10X5   = 5'd12;
    localparam logic [4:0] FMT_ASTC_10X6   = 5'd13;
    localparam logic [4:0] FMT_ASTC_8X8    = 5'd14;
    localparam logic [4:0] FMT_ASTC_10X8   = 5'd15;
    localparam logic [4:0] FMT_ASTC_10X10  = 5'd16;
    localparam logic [4:0] FMT_ASTC_12X10  = 5'd17;
    localparam logic [4:0] FMT_ASTC_12X12  = 5'd18;
    localparam logic [4:0] FORMAT_COUNT    = 5'd19;

    // Level end limit: 512 MiB
    localparam logic [63:0] LIMIT_BYTES = 64'h0000_0000_2000_0000;

    // Odd divisor factors left after the power-of-two part of a block side
    localparam logic [2:0] DIV_1 = 3'd1;
    localparam logic [2:0] DIV_3 = 3'd3;
    localparam logic [2:0] DIV_5 = 3'd5;

    // floor(2^33 / d) for the odd factors
    localparam logic [31:0] RECIP_3 = 32'hAAAA_AAAA;
    localparam logic [31:0] RECIP_5 = 32'h6666_6666;
    localparam int unsigned RECIP_SHIFT = 33;

    // Block side = div * 2^shift
    typedef struct packed {
        logic [1:0] shift;
        logic [2:0] div;
    } geo_dim_t;

    typedef struct packed {
        geo_dim_t w;
        geo_dim_t h;
        logic     wide_block;   // 16 bytes per block, else 4
    } geo_t;

    // Control of the shared multiplier
    typedef struct packed {
        logic       load;
        logic [2:0] div;
    } mclc_op_t;

    function automatic geo_dim_t dim_f(input logic [1:0] shift, input logic [2:0] div);
        geo_dim_t d;
        d.shift = shift;
        d.div   = div;
        return d;
    endfunction

    // Block geometry of each format; invalid codes fall back to 1x1
    function automatic geo_t geo_f(input logic [4:0] code);
        geo_t g;
        g.wide_block = (code != FMT_RGBA8);
        g.w = dim_f(2'd0, DIV_1);
        g.h = dim_f(2'd0, DIV_1);
        case (code)
            FMT_BC7, FMT_BC7_SRGB, FMT_BC3, FMT_ETC2, FMT_ASTC_4X4:
            begin
                g.w = dim_f(2'd2, DIV_1); g.h = dim_f(2'd2, DIV_1);
            end
            FMT_ASTC_5X4:   begin g.w = dim_f(2'd0, DIV_5); g.h = dim_f(2'd2, DIV_1); end
            FMT_ASTC_5X5:   begin g.w = dim_f(2'd0, DIV_5); g.h = dim_f(2'd0, DIV_5); end
            FMT_ASTC_6X5:   begin g.w = dim_f(2'd1, DIV_3); g.h = dim_f(2'd0, DIV_5); end
            FMT_ASTC_6X6:   begin g.w = dim_f(2'd1, DIV_3); g.h = dim_f(2'd1, DIV_3); end
            FMT_ASTC_8X5:   begin g.w = dim_f(2'd3, DIV_1); g.h = dim_f(2'd0, DIV_5); end
            FMT_ASTC_8X6:   begin g.w = dim_f(2'd3, DIV_1); g.h = dim_f(2'd1, DIV_3); end
            FMT_ASTC_10X5:  begin g.w = dim_f(2'd1, DIV_5); g.h = dim_f(2'd0, DIV_5); end
            FMT_ASTC_10X6:  begin g.w = dim_f(2'd1, DIV_5); g.h = dim_f(2'd1, DIV_3); end
            FMT_ASTC_8X8:   begin g.w = dim_f(2'd3, DIV_1); g.h = dim_f(2'd3, DIV_1); end
            FMT_ASTC_10X8:  begin g.w = dim_f(2'd1, DIV_5); g.h = dim_f(2'd3, DIV_1); end
            FMT_ASTC_10X10: begin g.w = dim_f(2'd1, DIV_5); g.h = dim_f(2'd1, DIV_5); end
            FMT_ASTC_12X10: begin g.w = dim_f(2'd2, DIV_3); g.h = dim_f(2'd1, DIV_5); end
            FMT_ASTC_12X12: begin g.w = dim_f(2'd2, DIV_3); g.h = dim_f(2'd2, DIV_3); end
            default:        begin g.w = dim_f(2'd0, DIV_1); g.h = dim_f(2'd0, DIV_1); end
        endcase
        return g;
    endfunction

    function automatic logic [31:0] recip_f(input logic [2:0] div);
        logic [31:0] r;
        case (div)
            DIV_3:   r = RECIP_3;
            DIV_5:   r = RECIP_5;
            default: r = '0;
        endcase
        return r;
    endfunction

    // ceil(v / 2^shift)
    function automatic logic [31:0] ceil_shift_f(input logic [31:0] v, input logic [1:0] shift);
        logic [31:0] mask;
        logic [31:0] q;
        mask = (32'd1 << shift) - 32'd1;
        q    = v >> shift;
        return q + {31'd0, |(v & mask)};
    endfunction

    // Halve toward one
    function automatic logic [31:0] half_f(input logic [31:0] v);
        logic [31:0] h;
        h = v >> 1;
        return (h == 32'd0) ? 32'd1 : h;
    endfunction

endpackage

`default_nettype wire

>>> src/mip_chain_layout_checker_top.sv
// ----------------------------------------------------------------------------
// mip_chain_layout_checker_top: mip chain layout checker
// A checked level record passes through three loads of the shared multiplier
// (S_LOADX, S_LOADY, S_LOADS), one check and one verdict step; a skipped
// record goes straight to the verdict step. A new record is taken only in
// S_IDLE, once the last one is through; a held verdict stalls the chain.
// Reset clears the registers and the chain state; no clearing pass is needed.
// Checks one level record per transaction against the layout that follows
// from format, base size and byte total, and gives one verdict on the last.
// ----------------------------------------------------------------------------
`default_nettype none

module mip_chain_layout_checker_top
    import mclc_pkg::*;
#(
    parameter int MAX_LEVELS = 16
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // configuration
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [31:0] cfg_wdata,
    // level records
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [31:0] level_width,
    input  wire logic [31:0] level_height,
    input  wire logic [31:0] blocks_x,
    input  wire logic [31:0] blocks_y,
    input  wire logic [63:0] byte_offset,
    input  wire logic [63:0] byte_size,
    input  wire logic [31:0] row_pitch,
    input  wire logic        last,
    // verdict
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic      [2:0]  status,
    output logic      [4:0]  failing_level
);

    localparam int CNT_W = $clog2(MAX_LEVELS + 2);

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOADX,
        S_LOADY,
        S_LOADS,
        S_CHECK,
        S_VERDICT
    } state_t;

    // Configuration registers
    logic [4:0]  fmt_reg;
    logic [31:0] base_w_reg;
    logic [31:0] base_h_reg;
    logic        gen_reg;
    logic [31:0] total_reg;

    // Chain state
    state_t           state_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [29:0]      offset_reg;
    logic [31:0]      exp_w_reg;
    logic [31:0]      exp_h_reg;
    logic [2:0]       first_error_reg;
    logic [4:0]       err_level_reg;

    // Held transaction
    logic [31:0] lw_reg;
    logic [31:0] lh_reg;
    logic [31:0] bx_in_reg;
    logic [31:0] by_in_reg;
    logic [63:0] boff_reg;
    logic [63:0] bsize_reg;
    logic [31:0] pitch_in_reg;
    logic        last_reg;
    logic [4:0]  idx_reg;

    // Work registers
    logic [31:0] bx_reg;
    logic [35:0] pitch_reg;

    // Verdict registers
    logic        out_valid_reg;
    logic [2:0]  status_reg;
    logic [4:0]  flevel_reg;

    // Combinational
    geo_t             geo;
    logic             header_bad;
    logic             accept;
    logic [CNT_W-1:0] cnt_inc;
    logic [31:0]      ew_start;
    logic [31:0]      eh_start;
    logic             do_level;
    logic [35:0]      pitch_calc;
    mclc_op_t         mul_op;
    logic [31:0]      mul_a;
    logic [31:0]      mul_b;
    logic [63:0]      prod;
    logic [31:0]      quot;
    logic             size_over;
    logic [30:0]      end_sum;
    logic             lim;
    logic             mism;
    logic             out_hold;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fmt_reg    <= FMT_RGBA8;
            base_w_reg <= '0;
            base_h_reg <= '0;
            gen_reg    <= 1'b0;
            total_reg  <= '0;
        end
        else if (cfg_we)
        begin
            priority case (cfg_index)
                CFG_FORMAT:   fmt_reg    <= cfg_wdata[4:0];
                CFG_BASE_W:   base_w_reg <= cfg_wdata;
                CFG_BASE_H:   base_h_reg <= cfg_wdata;
                CFG_GENERATE: gen_reg    <= cfg_wdata[0];
                CFG_TOTAL:    total_reg  <= cfg_wdata;
                default:      ;
            endcase
        end
    end

    // Decode header and the next level decision
    always_comb
    begin
        geo        = geo_f(fmt_reg);
        header_bad = (base_w_reg == 32'd0) || (base_h_reg == 32'd0) ||
                     (fmt_reg >= FORMAT_COUNT);
        accept     = in_valid && (state_reg == S_IDLE);
        cnt_inc    = (cnt_reg < CNT_W'(MAX_LEVELS + 1)) ? (cnt_reg + CNT_W'(1)) : cnt_reg;
        ew_start   = (cnt_reg == '0) ? base_w_reg : exp_w_reg;
        eh_start   = (cnt_reg == '0) ? base_h_reg : exp_h_reg;
        do_level   = !header_bad && (first_error_reg == ST_OK) &&
                     (cnt_reg < CNT_W'(MAX_LEVELS)) &&
                     (ew_start != 32'd0) && (eh_start != 32'd0);
        pitch_calc = geo.wide_block ? {bx_reg, 4'b0000} : {2'b00, bx_reg, 2'b00};
        out_hold   = out_valid_reg && out_stall;
    end

    // Drive the shared multiplier
    always_comb
    begin
        mul_op.load = 1'b0;
        mul_op.div  = DIV_1;
        mul_a       = '0;
        mul_b       = '0;
        unique case (state_reg)
            S_LOADX:
            begin
                mul_op.load = 1'b1;
                mul_op.div  = geo.w.div;
                mul_a       = ceil_shift_f(exp_w_reg, geo.w.shift);
                mul_b       = recip_f(geo.w.div);
            end
            S_LOADY:
            begin
                mul_op.load = 1'b1;
                mul_op.div  = geo.h.div;
                mul_a       = ceil_shift_f(exp_h_reg, geo.h.shift);
                mul_b       = recip_f(geo.h.div);
            end
            S_LOADS:
            begin
                mul_op.load = 1'b1;
                mul_op.div  = DIV_1;
                mul_a       = pitch_calc[31:0];
                mul_b       = quot;
            end
            S_IDLE, S_CHECK, S_VERDICT:
            begin
                mul_op.load = 1'b0;
            end
        endcase
    end

    mclc_shared_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .op    (mul_op),
        .op_a  (mul_a),
        .op_b  (mul_b),
        .prod  (prod),
        .quot  (quot)
    );

    // Check the level against the derived layout
    always_comb
    begin
        size_over = (prod > LIMIT_BYTES);
        end_sum   = {1'b0, offset_reg} + {1'b0, prod[29:0]};
        lim       = (pitch_reg[35:32] != 4'd0) || size_over ||
                    (end_sum > 31'(LIMIT_BYTES));
        mism      = (lw_reg != exp_w_reg) || (lh_reg != exp_h_reg) ||
                    (bx_in_reg != bx_reg) || (by_in_reg != mul_b_by()) ||
                    (boff_reg != {34'd0, offset_reg}) || (bsize_reg != prod) ||
                    ({4'd0, pitch_in_reg} != pitch_reg);
    end

    // Block rows are kept beside the pitch
    logic [31:0] by_reg;

    function automatic logic [31:0] mul_b_by();
        return by_reg;
    endfunction

    // Sequence the transaction and hold chain state and verdict
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            cnt_reg         <= '0;
            offset_reg      <= '0;
            exp_w_reg       <= '0;
            exp_h_reg       <= '0;
            first_error_reg <= ST_OK;
            err_level_reg   <= '0;
            lw_reg          <= '0;
            lh_reg          <= '0;
            bx_in_reg       <= '0;
            by_in_reg       <= '0;
            boff_reg        <= '0;
            bsize_reg       <= '0;
            pitch_in_reg    <= '0;
            last_reg        <= 1'b0;
            idx_reg         <= '0;
            bx_reg          <= '0;
            by_reg          <= '0;
            pitch_reg       <= '0;
            out_valid_reg   <= 1'b0;
            status_reg      <= ST_OK;
            flevel_reg      <= '0;
        end
        else
        begin
            // drop the verdict once taken
            if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        lw_reg       <= level_width;
                        lh_reg       <= level_height;
                        bx_in_reg    <= blocks_x;
                        by_in_reg    <= blocks_y;
                        boff_reg     <= byte_offset;
                        bsize_reg    <= byte_size;
                        pitch_in_reg <= row_pitch;
                        last_reg     <= last;
                        idx_reg      <= 5'(cnt_reg);
                        exp_w_reg    <= ew_start;
                        exp_h_reg    <= eh_start;
                        cnt_reg      <= cnt_inc;
                        state_reg    <= do_level ? S_LOADX : S_VERDICT;
                    end
                end
                S_LOADX:
                begin
                    state_reg <= S_LOADY;
                end
                S_LOADY:
                begin
                    bx_reg    <= quot;
                    state_reg <= S_LOADS;
                end
                S_LOADS:
                begin
                    by_reg    <= quot;
                    pitch_reg <= pitch_calc;
                    state_reg <= S_CHECK;
                end
                S_CHECK:
                begin
                    if (lim)
                    begin
                        first_error_reg <= ST_LIMIT;
                        err_level_reg   <= idx_reg;
                    end
                    else if (mism)
                    begin
                        first_error_reg <= ST_LEVEL;
                        err_level_reg   <= idx_reg;
                    end
                    else
                    begin
                        offset_reg <= end_sum[29:0];
                        exp_w_reg  <= half_f(exp_w_reg);
                        exp_h_reg  <= half_f(exp_h_reg);
                    end
                    state_reg <= S_VERDICT;
                end
                S_VERDICT:
                begin
                    if (!last_reg)
                        state_reg <= S_IDLE;
                    else if (!out_hold)
                    begin
                        out_valid_reg <= 1'b1;
                        flevel_reg    <= '0;
                        priority if (header_bad || (cnt_reg > CNT_W'(MAX_LEVELS)))
                            status_reg <= ST_HEADER;
                        else if (gen_reg && ((fmt_reg != FMT_RGBA8) ||
                                             (cnt_reg != CNT_W'(1))))
                            status_reg <= ST_GENERATE;
                        else if (first_error_reg != ST_OK)
                        begin
                            status_reg <= first_error_reg;
                            flevel_reg <= err_level_reg;
                        end
                        else if ({2'b00, offset_reg} != total_reg)
                            status_reg <= ST_TOTAL;
                        else
                            status_reg <= ST_OK;
                        // restart the chain
                        cnt_reg         <= '0;
                        offset_reg      <= '0;
                        exp_w_reg       <= '0;
                        exp_h_reg       <= '0;
                        first_error_reg <= ST_OK;
                        err_level_reg   <= '0;
                        state_reg       <= S_IDLE;
                    end
                end
            endcase
        end
    end

    assign in_stall      = (state_reg != S_IDLE);
    assign out_valid     = out_valid_reg;
    assign status        = status_reg;
    assign failing_level = flevel_reg;

    // Verdict codes stay in range
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (status_reg <= ST_TOTAL))
        else $error("verdict status out of range");

    // A failing level is reported only with a level error
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (flevel_reg != 5'd0)) |->
            ((status_reg == ST_LIMIT) || (status_reg == ST_LEVEL)))
        else $error("failing level reported with wrong status");

    // A level is computed only while no error is held
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_LOADX) |-> (first_error_reg == ST_OK))
        else $error("level computed after first error");

    // Running offset never passes the limit
    assert property (@(posedge clk) disable iff (!rst_n)
        ({34'd0, offset_reg} <= LIMIT_BYTES))
        else $error("expected offset past limit");

    // A delivered verdict restarts the chain
    assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_VERDICT) && last_reg && !out_hold) |=>
            (out_valid_reg && (cnt_reg == '0) && (state_reg == S_IDLE)))
        else $error("verdict did not restart chain");

endmodule

`default_nettype wire

>>> src/mclc_shared_mul.sv
// ----------------------------------------------------------------------------
// mclc_shared_mul: shared 32x32 multiplier with ceiling-division correction
// Each load registers one product. The product serves either as a plain
// 64-bit result or as a reciprocal estimate of x / div, which is corrected
// by one compare and subtract and rounded up to give ceil(x / div).
// ----------------------------------------------------------------------------
`default_nettype none

module mclc_shared_mul
    import mclc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire mclc_op_t    op,
    input  wire logic [31:0] op_a,
    input  wire logic [31:0] op_b,
    output logic      [63:0] prod,
    output logic      [31:0] quot
);

    logic [63:0] prod_reg;
    logic [31:0] x_reg;
    logic [2:0]  div_reg;

    logic [31:0] q0;
    logic [33:0] qm;
    logic [33:0] rem0;
    logic        fix;
    logic [31:0] q1;
    logic [33:0] rem1;

    // Register product and operands on load
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_reg <= '0;
            x_reg    <= '0;
            div_reg  <= DIV_1;
        end
        else if (op.load)
        begin
            prod_reg <= op_a * op_b;
            x_reg    <= op_a;
            div_reg  <= op.div;
        end
    end

    // Correct the reciprocal estimate, which is low by at most one
    always_comb
    begin
        q0 = {1'b0, prod_reg[63:RECIP_SHIFT]};
        if (div_reg == DIV_3)
            qm = {2'b00, q0} + {1'b0, q0, 1'b0};
        else
            qm = {2'b00, q0} + {q0, 2'b00};
        rem0 = {2'b00, x_reg} - qm;
        fix  = (rem0 >= {31'd0, div_reg});
        q1   = q0 + {31'd0, fix};
        rem1 = fix ? (rem0 - {31'd0, div_reg}) : rem0;
        if (div_reg == DIV_1)
            quot = x_reg;
        else
            quot = q1 + {31'd0, (rem1 != 34'd0)};
    end

    assign prod = prod_reg;

endmodule

`default_nettype wire

>>> tb/mclc_layout_checker.sv
// ----------------------------------------------------------------------------
// mclc_layout_checker: scoreboard for the mip chain layout checker
// Watches the configuration port and both record channels, keeps its own
// copy of the registers and the chain state, predicts the verdict of every
// chain and compares each verdict transaction with the oldest prediction.
// ----------------------------------------------------------------------------
module mclc_layout_checker
    import mclc_pkg::*;
#(
    parameter int MAX_LEVELS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_wdata,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [31:0] level_width,
    input  logic [31:0] level_height,
    input  logic [31:0] blocks_x,
    input  logic [31:0] blocks_y,
    input  logic [63:0] byte_offset,
    input  logic [63:0] byte_size,
    input  logic [31:0] row_pitch,
    input  logic        last,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [2:0]  status,
    input  logic [4:0]  failing_level,
    output int          mismatches,
    output int          pending,
    output int          verdicts_checked,
    output logic [5:0]  status_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [2:0] status;
        logic [4:0] level;
    } verdict_t;

    verdict_t verdicts_due[$];

    // Shadow copy of the registers
    logic [4:0]  cfg_fmt;
    logic [31:0] cfg_base_w;
    logic [31:0] cfg_base_h;
    logic        cfg_gen;
    logic [31:0] cfg_total;

    // Chain state
    int unsigned lvl_count;
    logic [63:0] run_off;
    logic [31:0] run_w;
    logic [31:0] run_h;
    logic [2:0]  first_err;
    logic [4:0]  err_lvl;

    // Block footprint in pixels of each format
    function automatic void footprint(input logic [4:0] f, output logic [63:0] bw,
                                      output logic [63:0] bh);
        case (f)
            FMT_BC7, FMT_BC7_SRGB, FMT_BC3, FMT_ETC2, FMT_ASTC_4X4:
            begin
                bw = 4; bh = 4;
            end
            FMT_ASTC_5X4:   begin bw = 5;  bh = 4;  end
            FMT_ASTC_5X5:   begin bw = 5;  bh = 5;  end
            FMT_ASTC_6X5:   begin bw = 6;  bh = 5;  end
            FMT_ASTC_6X6:   begin bw = 6;  bh = 6;  end
            FMT_ASTC_8X5:   begin bw = 8;  bh = 5;  end
            FMT_ASTC_8X6:   begin bw = 8;  bh = 6;  end
            FMT_ASTC_10X5:  begin bw = 10; bh = 5;  end
            FMT_ASTC_10X6:  begin bw = 10; bh = 6;  end
            FMT_ASTC_8X8:   begin bw = 8;  bh = 8;  end
            FMT_ASTC_10X8:  begin bw = 10; bh = 8;  end
            FMT_ASTC_10X10: begin bw = 10; bh = 10; end
            FMT_ASTC_12X10: begin bw = 12; bh = 10; end
            FMT_ASTC_12X12: begin bw = 12; bh = 12; end
            default:        begin bw = 1;  bh = 1;  end
        endcase
    endfunction

    function automatic logic [31:0] halve_to_one(input logic [31:0] v);
        return (v > 32'd1) ? (v >> 1) : 32'd1;
    endfunction

    task automatic open_chain();
        lvl_count = 0;
        run_off   = '0;
        run_w     = '0;
        run_h     = '0;
        first_err = ST_OK;
        err_lvl   = '0;
    endtask

    task automatic report(input string what, input longint unsigned want,
                          input longint unsigned got);
        mismatches++;
        if (mismatches <= 30)
            $display("%0t ns: %s: expected %0d, got %0d", $time, what, want, got);
    endtask

    // Advance the chain by one level record; queue a verdict on the last one
    task automatic take_record();
        int unsigned idx;
        logic        bad_header;
        logic [63:0] bw;
        logic [63:0] bh;
        logic [63:0] bx;
        logic [63:0] by;
        logic [63:0] pitch;
        logic [63:0] size;
        logic [2:0]  lvl_st;
        verdict_t    v;

        idx = lvl_count;
        if (idx == 0)
        begin
            run_w = cfg_base_w;
            run_h = cfg_base_h;
        end
        if (lvl_count < MAX_LEVELS + 1)
            lvl_count++;
        bad_header = (cfg_base_w == 0) || (cfg_base_h == 0) || (cfg_fmt >= FORMAT_COUNT);

        if (!bad_header && first_err == ST_OK && idx < MAX_LEVELS && run_w != 0 && run_h != 0)
        begin
            footprint(cfg_fmt, bw, bh);
            bx     = ({32'd0, run_w} + bw - 64'd1) / bw;
            by     = ({32'd0, run_h} + bh - 64'd1) / bh;
            pitch  = bx * ((cfg_fmt == FMT_RGBA8) ? 64'd4 : 64'd16);
            size   = pitch * by;
            lvl_st = ST_OK;
            if (pitch > 64'hFFFF_FFFF)
                lvl_st = ST_LIMIT;
            else if (size > LIMIT_BYTES || run_off + size > LIMIT_BYTES)
                lvl_st = ST_LIMIT;
            else if (level_width != run_w || level_height != run_h ||
                     {32'd0, blocks_x} != bx || {32'd0, blocks_y} != by ||
                     byte_offset != run_off || byte_size != size ||
                     {32'd0, row_pitch} != pitch)
                lvl_st = ST_LEVEL;

            if (lvl_st != ST_OK)
            begin
                first_err = lvl_st;
                err_lvl   = idx[4:0];
            end
            else
            begin
                run_off = run_off + size;
                run_w   = halve_to_one(run_w);
                run_h   = halve_to_one(run_h);
            end
        end

        if (last)
        begin
            v.level = '0;
            if (bad_header || lvl_count > MAX_LEVELS)
                v.status = ST_HEADER;
            else if (cfg_gen && (cfg_fmt != FMT_RGBA8 || lvl_count != 1))
                v.status = ST_GENERATE;
            else if (first_err != ST_OK)
            begin
                v.status = first_err;
                v.level  = err_lvl;
            end
            else if (run_off != {32'd0, cfg_total})
                v.status = ST_TOTAL;
            else
                v.status = ST_OK;
            verdicts_due.push_back(v);
            open_chain();
        end
    endtask

    // Track registers, predict on accepted records, compare accepted verdicts
    always @(posedge clk or negedge rst_n)
    begin
        verdict_t due;
        if (!rst_n)
        begin
            cfg_fmt          = FMT_RGBA8;
            cfg_base_w       = '0;
            cfg_base_h       = '0;
            cfg_gen          = 1'b0;
            cfg_total        = '0;
            mismatches       = 0;
            verdicts_checked = 0;
            status_seen      = '0;
            verdicts_due.delete();
            open_chain();
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_FORMAT:   cfg_fmt    = cfg_wdata[4:0];
                    CFG_BASE_W:   cfg_base_w = cfg_wdata;
                    CFG_BASE_H:   cfg_base_h = cfg_wdata;
                    CFG_GENERATE: cfg_gen    = cfg_wdata[0];
                    CFG_TOTAL:    cfg_total  = cfg_wdata;
                    default: ;
                endcase
            end

            if (in_valid && !in_stall)
                take_record();

            if (out_valid && !out_stall)
            begin
                if (verdicts_due.size() == 0)
                    report("verdict with none due, status", 0, status);
                else
                begin
                    due = verdicts_due.pop_front();
                    verdicts_checked++;
                    status_seen[due.status] = 1'b1;
                    if (status != due.status)
                        report("status", due.status, status);
                    if (failing_level != due.level)
                        report("failing_level", due.level, failing_level);
                end
            end
        end
        pending = verdicts_due.size();
    end

endmodule

>>> tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: testbench of the mip chain layout checker
// Configures format, base size, generate flag and byte total, then drives
// mip chains: directed corner cases first, then random chains that are mostly
// well formed with occasional damaged fields and noise records. Both channels
// idle at random; the verdict side holds off once long enough to back the
// block up. A separate scoreboard predicts and compares every verdict.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import mclc_pkg::*;

    localparam int         CHAIN_MAX       = 16;
    localparam int         ITEM_TARGET     = 1700;
    localparam int         CYCLE_LIMIT     = 400000;
    localparam int         HOLD_CYCLES     = 300;
    localparam int         SETTLE_CYCLES   = 8;
    localparam logic [4:0] FMT_UNUSED_HIGH = 5'd31;

    typedef enum {DAMAGE_NONE, DAMAGE_RANDOM, DAMAGE_LAST, DAMAGE_NOISE} damage_e;

    typedef struct {
        logic [31:0] lw;
        logic [31:0] lh;
        logic [31:0] bx;
        logic [31:0] by;
        logic [63:0] off;
        logic [63:0] size;
        logic [31:0] pitch;
        logic        lst;
    } level_rec_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [31:0] cfg_wdata;
    logic        in_valid;
    logic        in_stall;
    logic [31:0] level_width;
    logic [31:0] level_height;
    logic [31:0] blocks_x;
    logic [31:0] blocks_y;
    logic [63:0] byte_offset;
    logic [63:0] byte_size;
    logic [31:0] row_pitch;
    logic        last;
    logic        out_valid;
    logic        out_stall;
    logic [2:0]  status;
    logic [4:0]  failing_level;
    int          mismatches;
    int          pending;
    int          verdicts_checked;
    logic [5:0]  status_seen;

    // Stimulus bookkeeping
    int          cycles = 0;
    int          items_sent = 0;
    int          chains_sent = 0;
    bit          idle_on = 1'b1;
    bit          hold_req = 1'b0;
    logic [4:0]  cur_fmt;
    logic [31:0] cur_w;
    logic [31:0] cur_h;

    mip_chain_layout_checker_top #(.MAX_LEVELS(CHAIN_MAX)) u_top (.*);

    mclc_layout_checker #(.MAX_LEVELS(CHAIN_MAX)) u_layout_chk (.*);

    always #6ns clk = ~clk;

    // Abort a hung run
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("tb_top failed");
            $finish;
        end
    end

    // Verdict side: random stalls, one long hold-off on request
    initial
    begin
        int hold_left;
        hold_left = 0;
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
                out_stall <= idle_on && ($urandom_range(99) < 8);
        end
    end

    function automatic void block_side(input logic [4:0] f, output logic [63:0] bw,
                                       output logic [63:0] bh);
        case (f)
            FMT_BC7, FMT_BC7_SRGB, FMT_BC3, FMT_ETC2, FMT_ASTC_4X4:
            begin
                bw = 4; bh = 4;
            end
            FMT_ASTC_5X4:   begin bw = 5;  bh = 4;  end
            FMT_ASTC_5X5:   begin bw = 5;  bh = 5;  end
            FMT_ASTC_6X5:   begin bw = 6;  bh = 5;  end
            FMT_ASTC_6X6:   begin bw = 6;  bh = 6;  end
            FMT_ASTC_8X5:   begin bw = 8;  bh = 5;  end
            FMT_ASTC_8X6:   begin bw = 8;  bh = 6;  end
            FMT_ASTC_10X5:  begin bw = 10; bh = 5;  end
            FMT_ASTC_10X6:  begin bw = 10; bh = 6;  end
            FMT_ASTC_8X8:   begin bw = 8;  bh = 8;  end
            FMT_ASTC_10X8:  begin bw = 10; bh = 8;  end
            FMT_ASTC_10X10: begin bw = 10; bh = 10; end
            FMT_ASTC_12X10: begin bw = 12; bh = 10; end
            FMT_ASTC_12X12: begin bw = 12; bh = 12; end
            default:        begin bw = 1;  bh = 1;  end
        endcase
    endfunction

    // Correct layout of one level, used to build well-formed chains
    function automatic void level_geometry(input logic [4:0] f, input logic [31:0] w,
                                           input logic [31:0] h, output logic [63:0] bx,
                                           output logic [63:0] by, output logic [63:0] pitch,
                                           output logic [63:0] size);
        logic [63:0] bw;
        logic [63:0] bh;
        block_side(f, bw, bh);
        bx    = ({32'd0, w} + bw - 64'd1) / bw;
        by    = ({32'd0, h} + bh - 64'd1) / bh;
        pitch = bx * ((f == FMT_RGBA8) ? 64'd4 : 64'd16);
        size  = pitch * by;
    endfunction

    function automatic logic [31:0] next_side(input logic [31:0] v);
        return (v > 32'd1) ? (v >> 1) : 32'd1;
    endfunction

    function automatic logic [63:0] chain_bytes(input logic [4:0] f, input logic [31:0] w,
                                                input logic [31:0] h, input int n);
        logic [63:0] sum;
        logic [63:0] bx;
        logic [63:0] by;
        logic [63:0] pitch;
        logic [63:0] size;
        sum = '0;
        for (int i = 0; i < n && i < CHAIN_MAX; i++)
        begin
            level_geometry(f, w, h, bx, by, pitch, size);
            sum = sum + size;
            w   = next_side(w);
            h   = next_side(h);
        end
        return sum;
    endfunction

    function automatic int levels_to_one(input logic [31:0] w, input logic [31:0] h);
        int n;
        n = 1;
        while ((w > 1 || h > 1) && n < CHAIN_MAX)
        begin
            w = next_side(w);
            h = next_side(h);
            n++;
        end
        return n;
    endfunction

    function automatic logic [63:0] wild64();
        return {$urandom, $urandom} >> $urandom_range(63);
    endfunction

    // Junk above a narrow register, so every bit of the write data moves
    function automatic logic [31:0] upper_junk(input int unsigned width);
        return ($urandom_range(3) == 0) ? ($urandom << width) : 32'd0;
    endfunction

    task automatic cfg_write(input logic [2:0] idx, input logic [31:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge clk);
    endtask

    task automatic set_config(input logic [4:0] f, input logic [31:0] w, input logic [31:0] h,
                              input bit gen, input logic [31:0] total);
        cfg_write(CFG_FORMAT, upper_junk(5) | {27'd0, f});
        cfg_write(CFG_BASE_W, w);
        if ($urandom_range(9) == 0)
            cfg_write(3'($urandom_range(7, CFG_TOTAL + 1)), $urandom);
        cfg_write(CFG_BASE_H, h);
        cfg_write(CFG_GENERATE, upper_junk(1) | {31'd0, gen});
        cfg_write(CFG_TOTAL, total);
        cfg_we  <= 1'b0;
        cur_fmt = f;
        cur_w   = w;
        cur_h   = h;
    endtask

    // Offer one level record and hold it until it is accepted
    task automatic send_rec(input level_rec_t r);
        bit stalled;
        if (idle_on)
        begin
            while ($urandom_range(99) < 8)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
        end
        in_valid     <= 1'b1;
        level_width  <= r.lw;
        level_height <= r.lh;
        blocks_x     <= r.bx;
        blocks_y     <= r.by;
        byte_offset  <= r.off;
        byte_size    <= r.size;
        row_pitch    <= r.pitch;
        last         <= r.lst;
        do
        begin
            @(negedge clk);
            stalled = in_stall;
            @(posedge clk);
        end
        while (stalled);
        items_sent++;
    endtask

    // Drain every due verdict, then let a skipped record run out
    task automatic wait_idle();
        in_valid <= 1'b0;
        do
            @(negedge clk);
        while (pending != 0);
        @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Send one chain of n levels laid out from the current registers
    task automatic send_chain(input int n, input damage_e mode);
        level_rec_t  r;
        logic [31:0] w;
        logic [31:0] h;
        logic [63:0] off;
        logic [63:0] bx;
        logic [63:0] by;
        logic [63:0] pitch;
        logic [63:0] size;
        int          target;
        int          pick;
        bit          noisy;

        w      = cur_w;
        h      = cur_h;
        off    = '0;
        target = -1;
        noisy  = 1'b0;
        case (mode)
            DAMAGE_LAST:  target = n - 1;
            DAMAGE_NOISE:
            begin
                target = n - 1;
                noisy  = 1'b1;
            end
            DAMAGE_RANDOM:
            begin
                pick = $urandom_range(99);
                if (pick >= 70)
                    target = $urandom_range(n - 1);
                noisy = (pick >= 90);
            end
            default: ;
        endcase

        for (int i = 0; i < n; i++)
        begin
            level_geometry(cur_fmt, w, h, bx, by, pitch, size);
            r.lw    = w;
            r.lh    = h;
            r.bx    = bx[31:0];
            r.by    = by[31:0];
            r.off   = off;
            r.size  = size;
            r.pitch = pitch[31:0];
            r.lst   = (i == n - 1);
            if (i == target && noisy)
            begin
                r.lw    = wild64();
                r.lh    = wild64();
                r.bx    = wild64();
                r.by    = wild64();
                r.off   = wild64();
                r.size  = wild64();
                r.pitch = wild64();
            end
            else if (i == target)
            begin
                // flip one bit of one claimed field
                case ($urandom_range(6))
                    0:       r.lw    ^= 32'd1 << $urandom_range(31);
                    1:       r.lh    ^= 32'd1 << $urandom_range(31);
                    2:       r.bx    ^= 32'd1 << $urandom_range(31);
                    3:       r.by    ^= 32'd1 << $urandom_range(31);
                    4:       r.off   ^= 64'd1 << $urandom_range(63);
                    5:       r.size  ^= 64'd1 << $urandom_range(63);
                    default: r.pitch ^= 32'd1 << $urandom_range(31);
                endcase
            end
            send_rec(r);
            off = off + size;
            w   = next_side(w);
            h   = next_side(h);
        end
        chains_sent++;
    endtask

    // One configuration phase: drain, write registers, send chains
    task automatic run_batch(input logic [4:0] f, input logic [31:0] w, input logic [31:0] h,
                             input bit gen, input int n, input int chains,
                             input logic [31:0] total, input damage_e mode,
                             input bit hold_out);
        wait_idle();
        set_config(f, w, h, gen, total);
        if (hold_out)
            hold_req = 1'b1;
        repeat (chains) send_chain(n, mode);
    endtask

    task automatic run_random_batch();
        logic [4:0]  f;
        logic [31:0] w;
        logic [31:0] h;
        logic [31:0] total;
        bit          gen;
        int          n;
        int          sel;

        f = ($urandom_range(19) == 0) ? 5'($urandom_range(31, FORMAT_COUNT))
                                      : 5'($urandom_range(FORMAT_COUNT - 1));
        sel = $urandom_range(99);
        if (sel < 3)
        begin
            w = $urandom_range(1) ? 32'd0 : 32'($urandom_range(1, 64));
            h = (w == 0) ? 32'($urandom_range(64)) : 32'd0;
        end
        else if (sel < 8)
        begin
            // far past the size limit
            w = $urandom;
            h = $urandom >> $urandom_range(31);
        end
        else if (sel < 14)
        begin
            w = 32'd1 << $urandom_range(8, 14);
            h = 32'd1 << $urandom_range(6, 13);
        end
        else
        begin
            w = $urandom_range(1, 1 << $urandom_range(1, 11));
            h = $urandom_range(1, 1 << $urandom_range(1, 11));
        end

        sel = $urandom_range(99);
        if (sel < 60)
            n = levels_to_one(w, h);
        else if (sel < 85)
            n = $urandom_range(1, CHAIN_MAX);
        else if (sel < 93)
            n = $urandom_range(CHAIN_MAX + 1, CHAIN_MAX + 4);
        else
            n = 1;

        gen = ($urandom_range(9) == 0);
        if (gen && $urandom_range(1))
        begin
            f = FMT_RGBA8;
            n = 1;
        end

        total = chain_bytes(f, w, h, n);
        sel   = $urandom_range(9);
        if (sel == 8)
            total = total + ($urandom_range(1) ? 32'($urandom_range(1, 16))
                                               : -32'($urandom_range(1, 16)));
        else if (sel == 9)
            total = $urandom;

        idle_on = !(items_sent >= 700 && items_sent < 1000);
        run_batch(f, w, h, gen, n, $urandom_range(1, 4), total, DAMAGE_RANDOM, 1'b0);
    endtask

    initial
    begin
        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = CFG_FORMAT;
        cfg_wdata    = '0;
        in_valid     = 1'b0;
        level_width  = '0;
        level_height = '0;
        blocks_x     = '0;
        blocks_y     = '0;
        byte_offset  = '0;
        byte_size    = '0;
        row_pitch    = '0;
        last         = 1'b0;
        cur_fmt      = FMT_RGBA8;
        cur_w        = '0;
        cur_h        = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: clean chain, generate rule both ways, bad headers
        run_batch(FMT_RGBA8, 4, 2, 1'b0, 3, 1, chain_bytes(FMT_RGBA8, 4, 2, 3),
                  DAMAGE_NONE, 1'b0);
        run_batch(FMT_RGBA8, 8, 8, 1'b1, 1, 1, chain_bytes(FMT_RGBA8, 8, 8, 1),
                  DAMAGE_NONE, 1'b0);
        run_batch(FMT_BC7, 8, 8, 1'b1, 1, 1, chain_bytes(FMT_BC7, 8, 8, 1),
                  DAMAGE_NONE, 1'b0);
        run_batch(FMT_BC3, 0, 16, 1'b0, 1, 1, 0, DAMAGE_NONE, 1'b0);
        run_batch(FMT_UNUSED_HIGH, 16, 16, 1'b0, 1, 1, 1024, DAMAGE_NONE, 1'b0);
        // Limits: second level ends past 512 MiB, then pitch overflow
        run_batch(FMT_RGBA8, 16384, 8192, 1'b0, 2, 1, 0, DAMAGE_NONE, 1'b0);
        run_batch(FMT_RGBA8, 32'hFFFF_FFFF, 1, 1'b0, 1, 1, 0, DAMAGE_NONE, 1'b0);
        run_batch(FMT_BC7_SRGB, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 1, 1, 0,
                  DAMAGE_NONE, 1'b0);
        // Byte total off, damaged level, noise record, odd ASTC footprint
        run_batch(FMT_ASTC_12X12, 25, 13, 1'b0, 1, 1,
                  chain_bytes(FMT_ASTC_12X12, 25, 13, 1) + 16, DAMAGE_NONE, 1'b0);
        run_batch(FMT_ETC2, 8, 8, 1'b0, 2, 1, chain_bytes(FMT_ETC2, 8, 8, 2),
                  DAMAGE_LAST, 1'b0);
        run_batch(FMT_RGBA8, 1, 1, 1'b0, 1, 1, 4, DAMAGE_NOISE, 1'b0);
        run_batch(FMT_ASTC_10X6, 37, 23, 1'b0, 6, 1, chain_bytes(FMT_ASTC_10X6, 37, 23, 6),
                  DAMAGE_NONE, 1'b0);

        // Back the block up behind a long verdict hold-off
        idle_on = 1'b0;
        run_batch(FMT_RGBA8, 1, 1, 1'b0, 1, 30, 4, DAMAGE_NONE, 1'b1);
        idle_on = 1'b1;

        while (items_sent < ITEM_TARGET)
            run_random_batch();

        wait_idle();
        $display("Covered %0d level records in %0d chains, %0d verdicts compared.",
                 items_sent, chains_sent, verdicts_checked);
        $display("Verdict kinds reached (bit per status, ok in bit 0): %b", status_seen);
        if (mismatches == 0 && pending == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

endmodule

>>> files.f
src/mclc_pkg.sv
src/mclc_shared_mul.sv
src/mip_chain_layout_checker_top.sv
tb/mclc_layout_checker.sv
tb/tb_top.sv
